### rtl/distance_to_frame_mapper_assert.svh
// Assertion macros used by the mapper control module.
// Each macro expects clk and arst_n in scope.
`ifndef DISTANCE_TO_FRAME_MAPPER_ASSERT_SVH
`define DISTANCE_TO_FRAME_MAPPER_ASSERT_SVH

// Same-cycle implication.
`define DFM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/dfm_pkg.sv
package dfm_pkg;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_QUERY  = 2'd1,
		OP_FRAMES = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_COUNT  = 2'd0,
		CFG_VENDOR = 2'd1,
		CFG_TOTAL  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_ERR = 2'd1,
		STAT_SAT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MUL_DIST,
		MUL_FRAME,
		MUL_PAST
	} mul_sel_t;

	typedef enum logic [1:0] {
		RES_PLAIN,
		RES_ERR,
		RES_FRAME
	} res_sel_t;

	typedef enum logic {
		DIV_QUERY,
		DIV_FACTOR
	} div_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LOAD,
		ST_FONE,
		ST_EMIT,
		ST_QMUL,
		ST_QDIST,
		ST_QWIN,
		ST_WRD,
		ST_WCHK,
		ST_QMUL2,
		ST_QNUM,
		ST_QCHK,
		ST_QDIV,
		ST_QFIN,
		ST_QERR,
		ST_FRD,
		ST_FMUL,
		ST_FVD,
		ST_FDIV,
		ST_FFIN
	} state_t;

	localparam int          MIN_ENTRIES = 3;
	localparam logic [17:0] ONE_Q16     = 18'd65536;
	localparam logic [17:0] FACTOR_MAX  = 18'h3FFFF;
	localparam int          DVD_W       = 57;
	localparam logic [5:0]  DIV_STEPS   = 6'd57;
	localparam logic [48:0] VD_MAX      = 49'h100_0000_0000;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] frame;
		logic [23:0] rate;
	} seg_t;

	typedef struct packed {
		logic     cap;
		logic     mem_wr;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     ld_dist;
		logic     walk_clr;
		logic     rd_last;
		logic     walk_adv;
		logic     walk_stop;
		logic     num_ld;
		logic     div_start;
		div_sel_t div_sel;
		logic     corr_one;
		logic     corr_ld;
		logic     emit;
		res_sel_t res_sel;
	} dfm_cmd_t;

	typedef struct packed {
		op_t  op;
		logic hit;
		logic walk_go;
		logic vendor;
		logic few;
		logic rate_zero;
		logic num_neg;
		logic div_busy;
		logic out_free;
	} dfm_stat_t;

endpackage

### rtl/dfm_req_if.sv
interface dfm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  entry_index;
	logic [31:0] entry_distance;
	logic [31:0] entry_frame;
	logic [23:0] entry_rate;
	logic [31:0] query_distance;
	logic [31:0] frame_total;

	modport source (output valid, operation, entry_index, entry_distance, entry_frame,
		entry_rate, query_distance, frame_total, input ready);
	modport sink (input valid, operation, entry_index, entry_distance, entry_frame,
		entry_rate, query_distance, frame_total, output ready);
endinterface

### rtl/dfm_rsp_if.sv
interface dfm_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] frame_number;
	logic [23:0] segment_rate;
	logic [1:0]  status;
	logic [17:0] factor_out;

	modport source (output valid, frame_number, segment_rate, status, factor_out,
		input ready);
	modport sink (input valid, frame_number, segment_rate, status, factor_out,
		output ready);
endinterface

### rtl/dfm_datapath.sv
module dfm_datapath
	import dfm_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dfm_cmd_t    cmd,
	output dfm_stat_t   stat,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [1:0]  operation,
	input  logic [7:0]  entry_index,
	input  logic [31:0] entry_distance,
	input  logic [31:0] entry_frame,
	input  logic [23:0] entry_rate,
	input  logic [31:0] query_distance,
	input  logic [31:0] frame_total,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [31:0] frame_number,
	output logic [23:0] segment_rate,
	output logic [1:0]  status,
	output logic [17:0] factor_out
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// Configuration
	logic [8:0]  ec_q;
	logic        vendor_q;
	logic [31:0] total_q;

	// Captured item
	logic [1:0]  op_q;
	logic [7:0]  idx_q;
	seg_t        ld_q;
	logic [31:0] qd_q;
	logic [31:0] ft_q;

	seg_t        mem [TABLE_DEPTH];
	seg_t        rd_q;
	logic [AW-1:0] rd_addr;

	logic [CW-1:0] n;
	logic [CW-1:0] nm1;
	logic [CW-1:0] i_q;

	logic [31:0] cs_q, cf_q, wl_q, wh_q, d_q;
	logic [23:0] cr_q;
	logic [17:0] corr_q;

	logic [31:0] mul_a;
	logic [23:0] mul_b;
	logic [55:0] prod_q;
	logic [31:0] past;
	logic [57:0] num_q;
	logic [32:0] diff;
	logic [57:0] diff_x;
	logic [48:0] vd_sum;
	logic [40:0] vd;

	logic [DVD_W-1:0] dvd_q;
	logic [31:0]      rem_q;
	logic [31:0]      dsr_q;
	logic [5:0]       cnt_q;
	logic [32:0]      trial;
	logic             fits;

	logic        out_valid_q;
	logic [31:0] frame_q;
	logic [23:0] rate_q;
	logic [1:0]  status_q;
	logic [17:0] fac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_q     <= '0;
			vendor_q <= 1'b0;
			total_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_COUNT:  ec_q     <= cfg_data[8:0];
				CFG_VENDOR: vendor_q <= cfg_data[0];
				CFG_TOTAL:  total_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q     <= operation;
			idx_q    <= entry_index;
			ld_q     <= '{start: entry_distance, frame: entry_frame, rate: entry_rate};
			qd_q     <= query_distance;
			ft_q     <= frame_total;
		end
	end

	assign n   = (32'(ec_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(ec_q);
	assign nm1 = n - CW'(1);
	assign rd_addr = cmd.rd_last ? nm1[AW-1:0] : i_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.mem_wr && (32'(idx_q) < 32'(TABLE_DEPTH)))
			mem[AW'(idx_q)] <= ld_q;
		rd_q <= mem[rd_addr];
	end

	// Shared 32x24 multiplier
	assign past = (ft_q > rd_q.frame) ? (ft_q - rd_q.frame) : 32'd0;

	always_comb begin
		case (cmd.mul_sel)
			MUL_DIST: begin
				mul_a = qd_q;
				mul_b = {6'd0, corr_q};
			end
			MUL_FRAME: begin
				mul_a = cf_q;
				mul_b = cr_q;
			end
			default: begin
				mul_a = past;
				mul_b = rd_q.rate;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_q <= 56'(mul_a) * 56'(mul_b);
	end

	assign diff   = {1'b0, d_q} - {1'b0, cs_q};
	assign diff_x = {{25{diff[32]}}, diff};

	always_ff @(posedge clk) begin
		if (cmd.ld_dist)
			d_q <= (|prod_q[55:48]) ? 32'hFFFF_FFFF : prod_q[47:16];
		if (cmd.num_ld)
			num_q <= {2'b00, prod_q} + {diff_x[49:0], 8'd0};
	end

	// Cache, window, walk index and correction factor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q   <= '0;
			cf_q   <= '0;
			cr_q   <= '0;
			wl_q   <= '0;
			wh_q   <= '0;
			i_q    <= '0;
			corr_q <= ONE_Q16;
		end else begin
			if (cmd.walk_clr)
				i_q <= '0;
			if (cmd.walk_adv) begin
				cs_q <= rd_q.start;
				cf_q <= rd_q.frame;
				cr_q <= rd_q.rate;
				i_q  <= i_q + CW'(1);
			end
			if (cmd.walk_stop) begin
				wl_q <= cs_q;
				wh_q <= (i_q < n) ? rd_q.start : 32'd0;
			end
			if (cmd.corr_one)
				corr_q <= ONE_Q16;
			else if (cmd.corr_ld)
				corr_q <= (|dvd_q[DVD_W-1:18]) ? FACTOR_MAX : dvd_q[17:0];
		end
	end

	// Profile distance covered by the video, clamped to 2^40
	assign vd_sum = 49'(rd_q.start) + 49'(prod_q[55:8]);
	assign vd     = (vd_sum > VD_MAX) ? VD_MAX[40:0] : vd_sum[40:0];

	// Restoring divider, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (cmd.div_start)
			cnt_q <= DIV_STEPS;
		else if (cnt_q != 6'd0)
			cnt_q <= cnt_q - 6'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			if (cmd.div_sel == DIV_QUERY) begin
				dvd_q <= num_q[DVD_W-1:0];
				dsr_q <= {8'd0, cr_q};
			end else begin
				dvd_q <= {vd, 16'd0};
				dsr_q <= (total_q == 32'd0) ? 32'd1 : total_q;
			end
		end else if (cnt_q != 6'd0) begin
			rem_q <= fits ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			fac_q <= corr_q;
			case (cmd.res_sel)
				RES_ERR: begin
					frame_q  <= '0;
					rate_q   <= cr_q;
					status_q <= STAT_ERR;
				end
				RES_FRAME: begin
					rate_q <= cr_q;
					if (|dvd_q[DVD_W-1:32]) begin
						frame_q  <= 32'hFFFF_FFFF;
						status_q <= STAT_SAT;
					end else begin
						frame_q  <= dvd_q[31:0];
						status_q <= STAT_OK;
					end
				end
				default: begin
					frame_q  <= '0;
					rate_q   <= '0;
					status_q <= STAT_OK;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_number = frame_q;
	assign segment_rate = rate_q;
	assign status       = status_q;
	assign factor_out   = fac_q;

	assign stat.op        = op_t'(op_q);
	assign stat.hit       = (d_q > wl_q) && (d_q < wh_q);
	assign stat.walk_go   = (i_q < n) && (rd_q.start <= d_q);
	assign stat.vendor    = vendor_q;
	assign stat.few       = (32'(n) < 32'(MIN_ENTRIES));
	assign stat.rate_zero = (cr_q == 24'd0);
	assign stat.num_neg   = num_q[57];
	assign stat.div_busy  = (cnt_q != 6'd0);
	assign stat.out_free  = !out_valid_q || out_ready;

endmodule

### rtl/dfm_ctrl.sv
`include "distance_to_frame_mapper_assert.svh"

module dfm_ctrl
	import dfm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dfm_stat_t stat,
	output dfm_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.mul_sel = MUL_DIST;
		cmd.div_sel = DIV_QUERY;
		cmd.res_sel = RES_PLAIN;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (stat.op)
					OP_LOAD:   state_d = ST_LOAD;
					OP_QUERY:  state_d = ST_QMUL;
					OP_FRAMES: begin
						if (!stat.vendor)
							state_d = ST_EMIT;
						else if (stat.few)
							state_d = ST_FONE;
						else
							state_d = ST_FRD;
					end
					default:   state_d = ST_EMIT;
				endcase
			end
			ST_LOAD: begin
				cmd.mem_wr = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_FONE: begin
				cmd.corr_one = 1'b1;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_QMUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_QDIST;
			end
			ST_QDIST: begin
				cmd.ld_dist  = 1'b1;
				cmd.walk_clr = 1'b1;
				state_d      = ST_QWIN;
			end
			ST_QWIN: begin
				state_d = stat.hit ? ST_QMUL2 : ST_WRD;
			end
			ST_WRD: begin
				state_d = ST_WCHK;
			end
			ST_WCHK: begin
				if (stat.walk_go) begin
					cmd.walk_adv = 1'b1;
					state_d      = ST_WRD;
				end else begin
					cmd.walk_stop = 1'b1;
					state_d       = ST_QMUL2;
				end
			end
			ST_QMUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_FRAME;
				state_d     = ST_QNUM;
			end
			ST_QNUM: begin
				cmd.num_ld = 1'b1;
				state_d    = ST_QCHK;
			end
			ST_QCHK: begin
				if (stat.rate_zero || stat.num_neg) begin
					state_d = ST_QERR;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_QDIV;
				end
			end
			ST_QDIV: begin
				if (!stat.div_busy)
					state_d = ST_QFIN;
			end
			ST_QFIN: begin
				if (stat.out_free) begin
					cmd.emit    = 1'b1;
					cmd.res_sel = RES_FRAME;
					state_d     = ST_IDLE;
				end
			end
			ST_QERR: begin
				if (stat.out_free) begin
					cmd.emit    = 1'b1;
					cmd.res_sel = RES_ERR;
					state_d     = ST_IDLE;
				end
			end
			ST_FRD: begin
				cmd.rd_last = 1'b1;
				state_d     = ST_FMUL;
			end
			ST_FMUL: begin
				cmd.rd_last = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PAST;
				state_d     = ST_FVD;
			end
			ST_FVD: begin
				cmd.rd_last   = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_FACTOR;
				state_d       = ST_FDIV;
			end
			ST_FDIV: begin
				if (!stat.div_busy)
					state_d = ST_FFIN;
			end
			ST_FFIN: begin
				cmd.corr_ld = 1'b1;
				state_d     = ST_EMIT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`DFM_ASSERT_IMP(a_emit_free, cmd.emit, stat.out_free, "result emitted over a pending one")
	`DFM_ASSERT_NEXT(a_cap_dispatch, cmd.cap, state_q == ST_DISPATCH, "capture without dispatch")
	`DFM_ASSERT_IMP(a_idle_div, state_q == ST_IDLE, !stat.div_busy, "divider busy while idle")
	`DFM_ASSERT_IMP(a_div_start, cmd.div_start, !stat.div_busy, "divider restarted while busy")

endmodule

### rtl/distance_to_frame_mapper.sv
// Maps a rider distance to a video frame through a table of route segments.
// One item is taken at a time and gives one result. A frame-count item emits
// its result directly outside vendor mode, sets the factor to one with fewer
// than three entries, and otherwise runs a divide that is shared with queries.
// A query skips the table walk on a hit in the cached segment window; on a
// miss it walks the table entry by entry up to a stopping read. A zero rate
// or negative result skips the divide. The walk reads the segment memory
// through its single registered read port, so long tables set the query time.
// A new item is taken while the previous result still waits on the output.
module distance_to_frame_mapper
	import dfm_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	dfm_req_if.sink     req,
	dfm_rsp_if.source   rsp
);

	dfm_cmd_t  cmd;
	dfm_stat_t stat;

	// Sequence each item: capture, table access, multiply, divide, emit.
	dfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold the segment table, cache window, shared multiplier and divider.
	dfm_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.operation      (req.operation),
		.entry_index    (req.entry_index),
		.entry_distance (req.entry_distance),
		.entry_frame    (req.entry_frame),
		.entry_rate     (req.entry_rate),
		.query_distance (req.query_distance),
		.frame_total    (req.frame_total),
		.out_ready      (rsp.ready),
		.out_valid      (rsp.valid),
		.frame_number   (rsp.frame_number),
		.segment_rate   (rsp.segment_rate),
		.status         (rsp.status),
		.factor_out     (rsp.factor_out)
	);

endmodule
